// ===== hdl/ccs_pkg.sv =====
// shared types, character classes and scanner codes for the comment scanner
package ccs_pkg;

  localparam int COUNT_BITS_DEF  = 20;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_BITS        = 20;

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  typedef enum logic [2:0] {
    CC_OTHER     = 3'd0,
    CC_SLASH     = 3'd1,
    CC_STAR      = 3'd2,
    CC_QUOTE     = 3'd3,
    CC_BACKSLASH = 3'd4,
    CC_NEWLINE   = 3'd5
  } char_class_t;

  typedef enum logic [2:0] {
    MODE_TEXT   = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STAR   = 3'd4,
    MODE_STRING = 3'd5,
    MODE_ESCAPE = 3'd6
  } scan_mode_t;

  // one classified request between front and back
  typedef struct packed {
    logic        start;
    char_class_t cls;
  } token_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] start;
    logic [OUT_BITS-1:0] length;
    logic [OUT_BITS-1:0] line;
  } result_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    unique case (c)
      CH_SLASH:     r = CC_SLASH;
      CH_STAR:      r = CC_STAR;
      CH_QUOTE:     r = CC_QUOTE;
      CH_BACKSLASH: r = CC_BACKSLASH;
      CH_NEWLINE:   r = CC_NEWLINE;
      default:      r = CC_OTHER;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/c_comment_scanner.sv =====
// top level: byte classifier, token queue, scanner and result queue
// a closing byte is registered in the front, then passes the token queue and the scanner into the result queue
// throughput: one byte per cycle while neither queue is full, set by the scanner update in the back end
// the front stalls only when the token queue fills; the back stalls on a full result queue
// rst is synchronous and empties both queues and returns the scanner to text mode
// with all counters at zero; start_of_text only restarts the scanner, before the byte it comes with
module c_comment_scanner import ccs_pkg::*; #(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          text_byte,
  input  logic                start_of_text,
  input  logic                pop,
  output logic                empty,
  output logic [OUT_BITS-1:0] comment_start,
  output logic [OUT_BITS-1:0] comment_length,
  output logic [OUT_BITS-1:0] comment_line
);

  localparam int TOK_W = $bits(token_t);
  localparam int RES_W = $bits(result_t);

  logic             tok_push;
  token_t           tok_in;
  logic             tok_full;
  logic [TOK_W-1:0] tok_raw;
  token_t           tok_out;
  logic             tok_empty;
  logic             tok_pop;
  logic             res_push;
  result_t          res_in;
  logic             res_full;
  logic [RES_W-1:0] res_raw;
  result_t          res_out;

  ccs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .text_byte     (text_byte),
    .start_of_text (start_of_text),
    .tok_push      (tok_push),
    .tok_data      (tok_in),
    .tok_full      (tok_full)
  );

  ccs_queue #(
    .WIDTH (TOK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_tok_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (tok_push),
    .wr_data (tok_in),
    .full    (tok_full),
    .pop     (tok_pop),
    .rd_data (tok_raw),
    .empty   (tok_empty)
  );

  assign tok_out = token_t'(tok_raw);

  ccs_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_data  (tok_out),
    .tok_empty (tok_empty),
    .tok_pop   (tok_pop),
    .res_push  (res_push),
    .res_data  (res_in),
    .res_full  (res_full)
  );

  ccs_queue #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_raw),
    .empty   (empty)
  );

  assign res_out        = result_t'(res_raw);
  assign comment_start  = res_out.start;
  assign comment_length = res_out.length;
  assign comment_line   = res_out.line;

endmodule

// ===== hdl/ccs_queue.sv =====
// small first-in first-out queue with combinational head read
module ccs_queue import ccs_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CNT_W'(DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("pop did not drain an entry");

endmodule

// ===== hdl/ccs_front.sv =====
// front end: takes bytes, classifies them and feeds the token queue
module ccs_front import ccs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte,
  input  logic       start_of_text,
  output logic       tok_push,
  output token_t     tok_data,
  input  logic       tok_full
);

  logic   vld;
  token_t tok;
  logic   take;

  assign full     = vld && tok_full;
  assign take     = push && !full;
  assign tok_push = vld;
  assign tok_data = tok;

  always_ff @(posedge clk) begin
    if (take) begin
      tok.start <= start_of_text;
      tok.cls   <= classify(text_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= 1'b1;
    end else if (!tok_full) begin
      vld <= 1'b0;
    end
  end

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (vld && tok_full) |=> (vld && $stable(tok)))
    else $error("front token lost while queue full");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    take |=> vld)
    else $error("accepted byte not held");

  a_full_needs_token: assert property (@(posedge clk) disable iff (rst)
    full |-> vld)
    else $error("front reports full with nothing held");

endmodule

// ===== hdl/ccs_back.sv =====
// back end: scanner state, position, body length and line counters
module ccs_back import ccs_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  token_t  tok_data,
  input  logic    tok_empty,
  output logic    tok_pop,
  output logic    res_push,
  output result_t res_data,
  input  logic    res_full
);

  localparam int EXT_W = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  scan_mode_t            mode, mode_next;
  logic [COUNT_BITS-1:0] pos, pos_next;
  logic [COUNT_BITS-1:0] blen, blen_next;
  logic [COUNT_BITS-1:0] lines, lines_next;

  scan_mode_t            cur_mode;
  logic [COUNT_BITS-1:0] cur_pos;
  logic [COUNT_BITS-1:0] cur_blen;
  logic [COUNT_BITS-1:0] cur_lines;
  logic [COUNT_BITS-1:0] blen_inc;
  logic [COUNT_BITS-1:0] blen_inc2;
  logic [COUNT_BITS-1:0] base;
  logic [COUNT_BITS-1:0] body_start;
  logic                  emit;
  logic                  is_nl;
  logic [EXT_W-1:0]      ext_start;
  logic [EXT_W-1:0]      ext_len;
  logic [EXT_W-1:0]      ext_line;

  assign tok_pop = !tok_empty && !res_full;

  // a start flag restarts the scan before this byte
  assign cur_mode  = tok_data.start ? MODE_TEXT : mode;
  assign cur_pos   = tok_data.start ? '0 : pos;
  assign cur_blen  = tok_data.start ? '0 : blen;
  assign cur_lines = tok_data.start ? '0 : lines;
  assign is_nl     = (tok_data.cls == CC_NEWLINE);

  assign blen_inc  = (cur_blen == CNT_MAX) ? CNT_MAX : cur_blen + 1'b1;
  assign blen_inc2 = (cur_blen >= CNT_MAX - 1'b1) ? CNT_MAX : cur_blen + 2'd2;

  // closing slash sits one past the star, so back off one first
  assign base       = (cur_mode == MODE_STAR) ?
                      ((cur_pos > COUNT_BITS'(1)) ? cur_pos - 1'b1 : '0) : cur_pos;
  assign body_start = (base > cur_blen) ? base - cur_blen : '0;

  always_comb begin
    mode_next = cur_mode;
    blen_next = cur_blen;
    emit      = 1'b0;
    unique case (cur_mode)
      MODE_SLASH: begin
        case (tok_data.cls)
          CC_SLASH: mode_next = MODE_LINE;
          CC_STAR:  mode_next = MODE_BLOCK;
          CC_QUOTE: mode_next = MODE_STRING;
          default:  mode_next = MODE_TEXT;
        endcase
      end
      MODE_LINE: begin
        if (is_nl) begin
          emit      = 1'b1;
          blen_next = '0;
          mode_next = MODE_TEXT;
        end else begin
          blen_next = blen_inc;
        end
      end
      MODE_BLOCK: begin
        if (tok_data.cls == CC_STAR) begin
          mode_next = MODE_STAR;
        end else begin
          blen_next = blen_inc;
        end
      end
      MODE_STAR: begin
        case (tok_data.cls)
          CC_SLASH: begin
            emit      = 1'b1;
            blen_next = '0;
            mode_next = MODE_TEXT;
          end
          CC_STAR: blen_next = blen_inc;
          default: begin
            blen_next = blen_inc2;
            mode_next = MODE_BLOCK;
          end
        endcase
      end
      MODE_STRING: begin
        case (tok_data.cls)
          CC_QUOTE:     mode_next = MODE_TEXT;
          CC_BACKSLASH: mode_next = MODE_ESCAPE;
          default:      mode_next = MODE_STRING;
        endcase
      end
      MODE_ESCAPE: mode_next = MODE_STRING;
      default: begin
        case (tok_data.cls)
          CC_SLASH: mode_next = MODE_SLASH;
          CC_QUOTE: mode_next = MODE_STRING;
          default:  mode_next = MODE_TEXT;
        endcase
      end
    endcase
  end

  assign lines_next = (is_nl && cur_lines != CNT_MAX) ? cur_lines + 1'b1 : cur_lines;
  assign pos_next   = (cur_pos == CNT_MAX) ? CNT_MAX : cur_pos + 1'b1;

  assign ext_start = EXT_W'(body_start);
  assign ext_len   = EXT_W'(cur_blen);
  assign ext_line  = EXT_W'(cur_lines);

  assign res_push        = tok_pop && emit;
  assign res_data.start  = ext_start[OUT_BITS-1:0];
  assign res_data.length = ext_len[OUT_BITS-1:0];
  assign res_data.line   = ext_line[OUT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_TEXT;
      pos   <= '0;
      blen  <= '0;
      lines <= '0;
    end else if (tok_pop) begin
      mode  <= mode_next;
      pos   <= pos_next;
      blen  <= blen_next;
      lines <= lines_next;
    end
  end

  a_body_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_TEXT || mode == MODE_SLASH || mode == MODE_STRING ||
     mode == MODE_ESCAPE) |-> (blen == '0))
    else $error("body length left over outside a comment");

  a_emit_on_close: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (tok_data.cls == CC_NEWLINE || tok_data.cls == CC_SLASH))
    else $error("comment reported on a non-closing byte");

  a_pos_advances: assert property (@(posedge clk) disable iff (rst)
    tok_pop |=> (pos != '0))
    else $error("byte position did not advance");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_full |-> !tok_pop)
    else $error("request consumed while result queue full");

endmodule
